FILE: design/sdp_pkg.sv
// ---------------------------------------------------------------------------
// sdp_pkg
// Types and constants shared by the disparity reprojection block.
// ---------------------------------------------------------------------------
package sdp_pkg;

   localparam int QuoBits = 32;
   localparam int DivBits = 33;
   localparam int NumBits = 52;

   typedef enum logic [2:0] {
      REG_FOCAL_X        = 3'd0,
      REG_FOCAL_Y        = 3'd1,
      REG_CENTER_X       = 3'd2,
      REG_CENTER_Y       = 3'd3,
      REG_CENTER_X_RIGHT = 3'd4,
      REG_BASELINE_UM    = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [15:0]        pixel_u;
      logic [15:0]        pixel_v;
      logic signed [15:0] disparity;
   } req_data_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic               at_infinity;
      logic               clipped;
   } rsp_data_type;

   // one divider lane: partial remainder, numerator bits out / quotient bits in
   typedef struct packed {
      logic [DivBits-1:0] rem;
      logic [QuoBits-1:0] nq;
      logic               neg;
      logic               ovf;
   } lane_type;

   typedef struct packed {
      logic               valid;
      logic               inf;
      logic [DivBits-1:0] divisor;
      lane_type           lx;
      lane_type           ly;
      lane_type           lz;
   } stage_type;

endpackage

FILE: design/stereo_disparity_to_point_top.sv
// ---------------------------------------------------------------------------
// stereo_disparity_to_point_top
// Reprojects a pixel and its disparity to a 3D point in micrometres.
// ---------------------------------------------------------------------------
// req_*: one item per pixel (column, row, signed disparity in pixels).
// rsp_*: one item per request, in order: X, Y, Z, at_infinity, clipped.
// csr_*: register writes (index, data), always ready; write only when idle.
// The pipeline has 35 register stages: two product stages (the second also
// sets up the divider), 32 division cells (one quotient bit each) and the
// saturating output register. Throughput is one item per cycle while
// rsp_ready does not stall the pipeline.
// The whole pipeline advances together; when rsp_ready is low with a
// response pending, the pipeline and req_ready hold.
// Reset clears all valid bits and loads the default camera registers.
// ---------------------------------------------------------------------------
module stereo_disparity_to_point_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sdp_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sdp_pkg::rsp_data_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [19:0]           csr_data
);
   import sdp_pkg::*;

   logic [15:0] focal_x_ff, focal_y_ff, center_x_ff, center_y_ff, center_xr_ff;
   logic [19:0] baseline_ff;
   logic        en;
   stage_type   chain [0:QuoBits];
   logic         rsp_valid_ff;
   rsp_data_type rsp_data_ff, rsp_data_in;

   assign en        = ~rsp_valid_ff | rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff   <= 16'd8000;
         focal_y_ff   <= 16'd8000;
         center_x_ff  <= 16'd5120;
         center_y_ff  <= 16'd3840;
         center_xr_ff <= 16'd5120;
         baseline_ff  <= 20'd100000;
      end else if (csr_valid) begin
         case (csr_index)
            REG_FOCAL_X:        focal_x_ff   <= csr_data[15:0];
            REG_FOCAL_Y:        focal_y_ff   <= csr_data[15:0];
            REG_CENTER_X:       center_x_ff  <= csr_data[15:0];
            REG_CENTER_Y:       center_y_ff  <= csr_data[15:0];
            REG_CENTER_X_RIGHT: center_xr_ff <= csr_data[15:0];
            REG_BASELINE_UM:    baseline_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   sdp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .in_valid       (req_valid),
      .in_data        (req_data),
      .focal_x        (focal_x_ff),
      .focal_y        (focal_y_ff),
      .center_x       (center_x_ff),
      .center_y       (center_y_ff),
      .center_x_right (center_xr_ff),
      .baseline_um    (baseline_ff),
      .out_stage      (chain[0])
   );

   for (genvar i = 0; i < QuoBits; i++) begin : g_cell
      sdp_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .s_in  (chain[i]),
         .s_out (chain[i+1])
      );
   end

   function automatic logic [32:0] lane_sat(input lane_type l);
      logic [32:0] r;
      if (!l.neg) begin
         if (l.ovf || l.nq[31]) r = {1'b1, 32'h7fff_ffff};
         else                   r = {1'b0, l.nq};
      end else begin
         if (l.ovf || (l.nq > 32'h8000_0000)) r = {1'b1, 32'h8000_0000};
         else                                 r = {1'b0, 32'(-l.nq)};
      end
      return r;
   endfunction

   logic [32:0] sx, sy, sz;

   always_comb begin
      sx = lane_sat(chain[QuoBits].lx);
      sy = lane_sat(chain[QuoBits].ly);
      sz = lane_sat(chain[QuoBits].lz);
      if (chain[QuoBits].inf) begin
         rsp_data_in = '0;
         rsp_data_in.at_infinity = 1'b1;
      end else begin
         rsp_data_in.point_x     = sx[31:0];
         rsp_data_in.point_y     = sy[31:0];
         rsp_data_in.point_z     = sz[31:0];
         rsp_data_in.at_infinity = 1'b0;
         rsp_data_in.clipped     = sx[32] | sy[32] | sz[32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= chain[QuoBits].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_ready_follows_stall: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready)) else $error("req_ready mismatch");
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("response after reset");
   a_inf_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.at_infinity) |-> (rsp_data.point_x == 0 &&
      rsp_data.point_y == 0 && rsp_data.point_z == 0 && !rsp_data.clipped))
      else $error("infinite point not zeroed");

endmodule

FILE: design/sdp_front.sv
// ---------------------------------------------------------------------------
// sdp_front
// Product stages: forms W and the three numerator magnitudes, then sets up
// the first divider stage.
// ---------------------------------------------------------------------------
module sdp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  sdp_pkg::req_data_type in_data,
   input  logic [15:0]           focal_x,
   input  logic [15:0]           focal_y,
   input  logic [15:0]           center_x,
   input  logic [15:0]           center_y,
   input  logic [15:0]           center_x_right,
   input  logic [19:0]           baseline_um,
   output sdp_pkg::stage_type    out_stage
);
   import sdp_pkg::*;

   // stage a
   logic               a_valid_ff;
   logic signed [34:0] a_w_ff, a_w_in;
   logic [35:0]        a_p1_ff, a_p2_ff;
   logic [31:0]        a_p3_ff;
   logic [19:0]        a_b_ff;
   logic [15:0]        a_du_ff, a_dv_ff;
   logic               a_du_neg_ff, a_dv_neg_ff;
   logic signed [17:0] dd;
   logic signed [16:0] du, dv;

   // stage b
   logic               b_valid_ff;
   logic [NumBits-1:0] b_mx_ff, b_my_ff, b_mz_ff;
   logic [DivBits-1:0] b_wmag_ff;
   logic               b_inf_ff, b_wneg_ff, b_du_neg_ff, b_dv_neg_ff;
   logic [34:0]        wabs;

   always_comb begin
      dd = $signed({2'b00, center_x}) - $signed({2'b00, center_x_right})
           - 18'(in_data.disparity);
      du = $signed({1'b0, in_data.pixel_u}) - $signed({1'b0, center_x});
      dv = $signed({1'b0, in_data.pixel_v}) - $signed({1'b0, center_y});
      a_w_in = $signed({1'b0, focal_y}) * dd;
      wabs = a_w_ff[34] ? 35'(-a_w_ff) : 35'(a_w_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_w_ff      <= a_w_in;
         a_p1_ff     <= 36'(focal_y) * 36'(baseline_um);
         a_p2_ff     <= 36'(focal_x) * 36'(baseline_um);
         a_p3_ff     <= 32'(focal_x) * 32'(focal_y);
         a_b_ff      <= baseline_um;
         a_du_neg_ff <= du[16];
         a_dv_neg_ff <= dv[16];
         a_du_ff     <= du[16] ? 16'(-du) : du[15:0];
         a_dv_ff     <= dv[16] ? 16'(-dv) : dv[15:0];
         b_mx_ff     <= NumBits'(a_p1_ff) * NumBits'(a_du_ff);
         b_my_ff     <= NumBits'(a_p2_ff) * NumBits'(a_dv_ff);
         b_mz_ff     <= NumBits'(a_p3_ff) * NumBits'(a_b_ff);
         b_wmag_ff   <= wabs[DivBits-1:0];
         b_inf_ff    <= (a_w_ff == '0);
         b_wneg_ff   <= a_w_ff[34];
         b_du_neg_ff <= a_du_neg_ff;
         b_dv_neg_ff <= a_dv_neg_ff;
      end
   end

   // quotient above 32 bits when the top numerator bits reach the divisor
   function automatic lane_type lane_setup(input logic [NumBits-1:0] num,
                                           input logic [DivBits-1:0] dv_mag,
                                           input logic neg);
      lane_type l;
      l.rem = DivBits'(num[NumBits-1:QuoBits]);
      l.nq  = num[QuoBits-1:0];
      l.neg = neg;
      l.ovf = (DivBits'(num[NumBits-1:QuoBits]) >= dv_mag);
      return l;
   endfunction

   // numerator carries -baseline, so its sign flips that of the pixel offset
   always_comb begin
      out_stage.valid   = b_valid_ff;
      out_stage.inf     = b_inf_ff;
      out_stage.divisor = b_wmag_ff;
      out_stage.lx      = lane_setup(b_mx_ff, b_wmag_ff, ~b_du_neg_ff ^ b_wneg_ff);
      out_stage.ly      = lane_setup(b_my_ff, b_wmag_ff, ~b_dv_neg_ff ^ b_wneg_ff);
      out_stage.lz      = lane_setup(b_mz_ff, b_wmag_ff, ~b_wneg_ff);
   end

endmodule

FILE: design/sdp_div_cell.sv
// ---------------------------------------------------------------------------
// sdp_div_cell
// One restoring-division cell: settles one quotient bit of all three lanes
// and hands the item to the next cell.
// ---------------------------------------------------------------------------
module sdp_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  sdp_pkg::stage_type s_in,
   output sdp_pkg::stage_type s_out
);
   import sdp_pkg::*;

   stage_type s_ff, s_in_next;

   function automatic lane_type lane_step(input lane_type l,
                                          input logic [DivBits-1:0] d);
      lane_type o;
      logic [DivBits:0] r;
      logic             bit_q;
      r     = {l.rem, l.nq[QuoBits-1]};
      bit_q = (r >= {1'b0, d});
      o     = l;
      o.rem = bit_q ? DivBits'(r - {1'b0, d}) : r[DivBits-1:0];
      o.nq  = {l.nq[QuoBits-2:0], bit_q};
      return o;
   endfunction

   always_comb begin
      s_in_next    = s_in;
      s_in_next.lx = lane_step(s_in.lx, s_in.divisor);
      s_in_next.ly = lane_step(s_in.ly, s_in.divisor);
      s_in_next.lz = lane_step(s_in.lz, s_in.divisor);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_ff <= '0;
      end else if (en) begin
         s_ff <= s_in_next;
      end
   end

   assign s_out = s_ff;

endmodule
